FILE: design/ptq_pkg.sv
package ptq_pkg;

	localparam int TIMERS_DEF      = 8;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int FRONT_DEPTH     = 2;
	localparam logic [3:0] DROP_MAX = 4'hF;

	typedef enum logic [1:0] {
		OP_SET  = 2'd0,
		OP_TICK = 2'd1,
		OP_POST = 2'd2,
		OP_POP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_NULL  = 2'd3
	} status_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  id;
		logic [7:0]  param;
		logic [15:0] period;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  param;
		logic [15:0] count;
		logic [15:0] period;
	} tmr_t;

	typedef struct packed {
		logic [7:0] id;
		logic [7:0] param;
	} ev_t;

	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

FILE: design/ptq_ram.sv
module ptq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [ptq_pkg::idx_w(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [ptq_pkg::idx_w(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);
	import ptq_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/ptq_front.sv
module ptq_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    func,
	input  logic [7:0]    event_id,
	input  logic [7:0]    event_param,
	input  logic [15:0]   period_ticks,
	output logic          cmd_valid,
	output ptq_pkg::cmd_t cmd,
	input  logic          cmd_take
);
	import ptq_pkg::*;

	localparam int PW = idx_w(FRONT_DEPTH);
	localparam int CW = $clog2(FRONT_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(FRONT_DEPTH - 1);

	cmd_t          entry_q [FRONT_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_take;
	cmd_t          req;

	assign full      = (cnt_q == CW'(FRONT_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = entry_q[rd_q];
	assign do_push   = push && !full;
	assign do_take   = cmd_take && cmd_valid;

	// pack the request fields into a command, with func as its operation code
	always_comb begin
		req.op     = op_t'(func);
		req.id     = event_id;
		req.param  = event_param;
		req.period = period_ticks;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			end
			if (do_take) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_take) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!do_push && do_take) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= req;
		end
	end

endmodule

FILE: design/ptq_back.sv
module ptq_back #(
	parameter int TIMERS      = ptq_pkg::TIMERS_DEF,
	parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  ptq_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic          empty,
	input  logic          pop,
	output logic [1:0]    status,
	output logic [7:0]    out_id,
	output logic [7:0]    out_param,
	output logic [3:0]    dropped
);
	import ptq_pkg::*;

	localparam int TW = idx_w(TIMERS);
	localparam int QW = idx_w(QUEUE_DEPTH);
	localparam logic [TW-1:0] LAST_SLOT = TW'(TIMERS - 1);
	localparam logic [QW-1:0] LAST_PTR  = QW'(QUEUE_DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SET_WR,
		S_POP_RD
	} state_t;

	state_t        state_q;
	cmd_t          cmd_q;
	logic [TW-1:0] scan_q;
	logic          match_hit_q;
	logic [TW-1:0] match_q;
	logic          free_hit_q;
	logic [TW-1:0] free_q;
	logic [3:0]    drop_q;
	logic [QW-1:0] head_q;
	logic [QW-1:0] tail_q;
	logic [TIMERS-1:0] tvalid_q;
	logic          out_valid_q;
	status_t       status_q;
	logic [7:0]    out_id_q;
	logic [7:0]    out_param_q;
	logic [3:0]    dropped_q;

	logic          t_we;
	logic [TW-1:0] t_waddr;
	tmr_t          t_wdata;
	logic [TW-1:0] t_raddr;
	tmr_t          t_rdata;
	logic          q_we;
	ev_t           q_wdata;
	ev_t           q_rdata;

	tmr_t          tent;
	logic          active;
	logic          fire;
	logic [QW-1:0] head_nx;
	logic [QW-1:0] tail_nx;
	logic          overwrite;
	logic [3:0]    drop_nx;
	logic [TW-1:0] set_slot;

	function automatic logic [QW-1:0] next_ptr(input logic [QW-1:0] p);
		return (p == LAST_PTR) ? '0 : p + QW'(1);
	endfunction

	ptq_ram #(.WIDTH($bits(tmr_t)), .DEPTH(TIMERS)) u_tmr_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	ptq_ram #(.WIDTH($bits(ev_t)), .DEPTH(QUEUE_DEPTH)) u_evq_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (head_nx),
		.wdata (q_wdata),
		.raddr (tail_nx),
		.rdata (q_rdata)
	);

	// a slot never written reads as a free, zeroed entry
	assign tent      = tvalid_q[scan_q] ? t_rdata : '0;
	assign active    = (tent.id != 8'd0);
	assign fire      = (state_q == S_SCAN) && (cmd_q.op == OP_TICK) && active
	                   && (tent.count == 16'd0);
	assign head_nx   = next_ptr(head_q);
	assign tail_nx   = next_ptr(tail_q);
	assign overwrite = (head_nx == tail_q);
	assign drop_nx   = (fire && overwrite && drop_q != DROP_MAX) ? drop_q + 4'd1 : drop_q;
	assign set_slot  = match_hit_q ? match_q : free_q;

	assign cmd_take  = (state_q == S_IDLE) && cmd_valid && !out_valid_q;
	assign t_raddr   = (state_q == S_SCAN) ? scan_q + TW'(1) : '0;

	always_comb begin
		t_we    = 1'b0;
		t_waddr = scan_q;
		t_wdata = tent;
		if (state_q == S_SET_WR) begin
			t_we           = match_hit_q || free_hit_q;
			t_waddr        = set_slot;
			t_wdata.id     = cmd_q.id;
			t_wdata.param  = cmd_q.param;
			t_wdata.count  = cmd_q.period;
			t_wdata.period = cmd_q.period;
		end else if (state_q == S_SCAN && cmd_q.op == OP_TICK && active) begin
			t_we          = 1'b1;
			t_wdata.count = (tent.count == 16'd0) ? tent.period : tent.count - 16'd1;
		end
	end

	always_comb begin
		q_we          = fire;
		q_wdata.id    = tent.id;
		q_wdata.param = tent.param;
		if (state_q == S_IDLE) begin
			q_we          = cmd_take && (cmd.op == OP_POST);
			q_wdata.id    = cmd.id;
			q_wdata.param = cmd.param;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			scan_q      <= '0;
			match_hit_q <= 1'b0;
			match_q     <= '0;
			free_hit_q  <= 1'b0;
			free_q      <= '0;
			drop_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			tvalid_q    <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			out_id_q    <= '0;
			out_param_q <= '0;
			dropped_q   <= '0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						cmd_q       <= cmd;
						scan_q      <= '0;
						match_hit_q <= 1'b0;
						free_hit_q  <= 1'b0;
						drop_q      <= '0;
						out_id_q    <= '0;
						out_param_q <= '0;
						dropped_q   <= '0;
						status_q    <= ST_OK;
						case (cmd.op)
							OP_SET, OP_TICK: begin
								state_q <= S_SCAN;
							end
							OP_POST: begin
								head_q      <= head_nx;
								out_valid_q <= 1'b1;
								if (overwrite) begin
									tail_q    <= tail_nx;
									dropped_q <= 4'd1;
								end
							end
							OP_POP: begin
								if (head_q == tail_q) begin
									status_q    <= ST_EMPTY;
									out_valid_q <= 1'b1;
								end else begin
									tail_q  <= tail_nx;
									state_q <= S_POP_RD;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (fire) begin
						head_q <= head_nx;
						if (overwrite) begin
							tail_q <= tail_nx;
						end
					end
					drop_q <= drop_nx;
					if (cmd_q.op == OP_SET) begin
						// highest free slot wins, lowest matching slot wins
						if (!active) begin
							free_hit_q <= 1'b1;
							free_q     <= scan_q;
						end else if (!match_hit_q && tent.id == cmd_q.id
						             && tent.param == cmd_q.param) begin
							match_hit_q <= 1'b1;
							match_q     <= scan_q;
						end
					end
					if (scan_q == LAST_SLOT) begin
						if (cmd_q.op == OP_TICK) begin
							dropped_q   <= drop_nx;
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_SET_WR;
						end
					end else begin
						scan_q <= scan_q + TW'(1);
					end
				end
				S_SET_WR: begin
					if (match_hit_q || free_hit_q) begin
						tvalid_q[set_slot] <= 1'b1;
					end else begin
						status_q <= ST_FULL;
					end
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_POP_RD: begin
					if (q_rdata.id == 8'd0) begin
						status_q <= ST_NULL;
					end else begin
						out_id_q    <= q_rdata.id;
						out_param_q <= q_rdata.param;
					end
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign empty     = !out_valid_q;
	assign status    = status_q;
	assign out_id    = out_id_q;
	assign out_param = out_param_q;
	assign dropped   = dropped_q;

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !out_valid_q)
		else $error("request in progress while a result is pending");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && cmd.op == OP_POP && head_q == tail_q)
		|=> (out_valid_q && status_q == ST_EMPTY))
		else $error("pop of empty ring did not report empty");

	a_id_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_id_q != 8'd0) |-> status_q == ST_OK)
		else $error("message returned with a failure status");

	a_drop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dropped_q != 4'd0) |-> status_q == ST_OK)
		else $error("drop count on a failed request");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> scan_q <= LAST_SLOT)
		else $error("slot scan out of range");

endmodule

FILE: design/periodic_timer_event_queue.sv
// Periodic timer table with an event ring.
// Input channel: a request (func, event_id, event_param, period_ticks) is
// taken at a clock edge with push high and full low. A two-entry request
// queue sits in front, so requests keep coming while a result waits.
// Result channel: while empty is low, (status, out_id, out_param, dropped)
// holds the oldest result; it is taken at an edge with pop high.
// Exactly one result per request, in request order.
// The back end works one request at a time and walks the timer RAM one slot per
// cycle (one read port, one write port): a tick scans every slot, a set scans
// every slot and then writes the chosen one, a post is handled as it is taken,
// and a pop reads the ring entry in a separate read state.
// A new request starts only once the previous result has been taken; while
// the receiver holds pop low the front queue fills and then raises full.
// Reset (arst_n low) frees every timer slot, empties the ring and drops
// any queued request or pending result. Ring contents are not cleared;
// only entries written since reset are ever read.
module periodic_timer_event_queue #(
	parameter int TIMERS      = ptq_pkg::TIMERS_DEF,
	parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [7:0]  event_id,
	input  logic [7:0]  event_param,
	input  logic [15:0] period_ticks,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [7:0]  out_id,
	output logic [7:0]  out_param,
	output logic [3:0]  dropped
);
	import ptq_pkg::*;

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;

	ptq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.event_id     (event_id),
		.event_param  (event_param),
		.period_ticks (period_ticks),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take)
	);

	ptq_back #(.TIMERS(TIMERS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.status    (status),
		.out_id    (out_id),
		.out_param (out_param),
		.dropped   (dropped)
	);

endmodule

FILE: tb/ptq_event_checker.sv
`timescale 1ns / 100ps

module ptq_event_checker #(
	parameter int TIMERS      = ptq_pkg::TIMERS_DEF,
	parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  func,
	input  logic [7:0]  event_id,
	input  logic [7:0]  event_param,
	input  logic [15:0] period_ticks,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  status,
	input  logic [7:0]  out_id,
	input  logic [7:0]  out_param,
	input  logic [3:0]  dropped,
	output int          fail_count,
	output int          pending
);

	import ptq_pkg::*;

	typedef struct packed {
		status_t    status;
		logic [7:0] id;
		logic [7:0] param;
		logic [3:0] drops;
	} outcome_t;

	tmr_t     timer_tbl [TIMERS];
	ev_t      ring [QUEUE_DEPTH];
	int       newest;
	int       oldest;
	outcome_t outcome_q [$];
	outcome_t want;

	function automatic int ring_advance(input int p);
		return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
	endfunction

	// Returns 1 when the oldest entry gets overwritten.
	function automatic int ring_insert(input logic [7:0] id, input logic [7:0] par);
		newest = ring_advance(newest);
		ring[newest].id    = id;
		ring[newest].param = par;
		if (newest == oldest) begin
			oldest = ring_advance(oldest);
			return 1;
		end
		return 0;
	endfunction

	function automatic outcome_t predict_outcome(input op_t op, input logic [7:0] id,
			input logic [7:0] par, input logic [15:0] per);
		outcome_t r;
		int       hit;
		int       slot;
		int       drops;
		int       i;
		r.status = ST_OK;
		r.id     = '0;
		r.param  = '0;
		drops    = 0;
		case (op)
			OP_SET: begin
				hit  = -1;
				slot = -1;
				for (i = 0; i < TIMERS; i++) begin
					if (timer_tbl[i].id == 8'd0)
						slot = i;
					else if (hit < 0 && timer_tbl[i].id == id && timer_tbl[i].param == par)
						hit = i;
				end
				if (hit >= 0) begin
					timer_tbl[hit].count  = per;
					timer_tbl[hit].period = per;
				end else if (slot >= 0) begin
					// an id of zero lands here too and leaves the slot free
					timer_tbl[slot].id     = id;
					timer_tbl[slot].param  = par;
					timer_tbl[slot].count  = per;
					timer_tbl[slot].period = per;
				end else begin
					r.status = ST_FULL;
				end
			end
			OP_TICK: begin
				for (i = 0; i < TIMERS; i++) begin
					if (timer_tbl[i].id != 8'd0) begin
						if (timer_tbl[i].count == 16'd0) begin
							timer_tbl[i].count = timer_tbl[i].period;
							drops += ring_insert(timer_tbl[i].id, timer_tbl[i].param);
						end else begin
							timer_tbl[i].count = timer_tbl[i].count - 16'd1;
						end
					end
				end
			end
			OP_POST: begin
				drops = ring_insert(id, par);
			end
			default: begin
				if (newest == oldest) begin
					r.status = ST_EMPTY;
				end else begin
					oldest = ring_advance(oldest);
					if (ring[oldest].id == 8'd0) begin
						r.status = ST_NULL;
					end else begin
						r.id    = ring[oldest].id;
						r.param = ring[oldest].param;
					end
				end
			end
		endcase
		r.drops = (drops > DROP_MAX) ? DROP_MAX : 4'(drops);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMERS; i++)
				timer_tbl[i] = '0;
			newest     = 0;
			oldest     = 0;
			outcome_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// results leave only after their request has been taken, so check before predicting
			if (pop && !empty) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got status %0d id %0d",
						$time, status, out_id);
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					check_field("status", 8'(want.status), 8'(status));
					check_field("out_id", want.id, out_id);
					check_field("out_param", want.param, out_param);
					check_field("dropped", 8'(want.drops), 8'(dropped));
				end
			end
			if (push && !full)
				outcome_q.push_back(predict_outcome(op_t'(func), event_id, event_param,
					period_ticks));
			pending = outcome_q.size();
		end
	end

endmodule

FILE: tb/tb_periodic_timer_event_queue.sv
`timescale 1ns / 100ps

module tb_periodic_timer_event_queue;

	import ptq_pkg::*;

	localparam int TIMERS      = TIMERS_DEF;
	localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
	localparam int RANDOM_REQS = 1700;
	localparam int LONG_HOLD   = 300;
	localparam int HOLD_AT     = 400;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        push         = 1'b0;
	logic        pop          = 1'b0;
	logic [1:0]  func         = OP_SET;
	logic [7:0]  event_id     = '0;
	logic [7:0]  event_param  = '0;
	logic [15:0] period_ticks = '0;
	logic        full;
	logic        empty;
	logic [1:0]  status;
	logic [7:0]  out_id;
	logic [7:0]  out_param;
	logic [3:0]  dropped;
	int          fail_count;
	int          pending;
	int          cycles       = 0;
	int          sent         = 0;
	int          taken        = 0;
	bit          tx_steady    = 1'b0;
	bit          rx_steady    = 1'b0;

	always #2 clk = ~clk;

	periodic_timer_event_queue #(
		.TIMERS      (TIMERS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.event_id     (event_id),
		.event_param  (event_param),
		.period_ticks (period_ticks),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.out_id       (out_id),
		.out_param    (out_param),
		.dropped      (dropped)
	);

	ptq_event_checker #(
		.TIMERS      (TIMERS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.event_id     (event_id),
		.event_param  (event_param),
		.period_ticks (period_ticks),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.out_id       (out_id),
		.out_param    (out_param),
		.dropped      (dropped),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("tb_periodic_timer_event_queue: errors");
			$finish;
		end
	end

	// The id/param pairs that the timer table gets filled with.
	function automatic ev_t pool_timer(input int k);
		ev_t e;
		e.id    = (k == 0) ? 8'd255 : 8'(k);
		e.param = 8'(255 - k * 17);
		return e;
	endfunction

	task automatic send_req(input op_t op, input logic [7:0] id, input logic [7:0] par,
			input logic [15:0] per);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 19);
		if ($urandom_range(0, 49) == 0)
			tx_steady = !tx_steady;
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push         <= 1'b1;
		func         <= op;
		event_id     <= id;
		event_param  <= par;
		period_ticks <= per;
		do
			@(posedge clk);
		while (full);
		sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Receiver: random stalls, one long hold-off to back the block up.
	initial begin
		int hold;
		wait (arst_n);
		forever begin
			hold = rx_steady ? 0 : $urandom_range(0, 19);
			if (taken == HOLD_AT)
				hold = LONG_HOLD;
			if ($urandom_range(0, 49) == 0)
				rx_steady = !rx_steady;
			repeat (hold) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			@(negedge clk);
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
			taken++;
		end
	end

	initial begin
		op_t         op;
		logic [7:0]  id;
		logic [7:0]  par;
		logic [15:0] per;
		ev_t         t;
		int          pick;
		bit          drain_mix;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_req(OP_POP, 8'd0, 8'd0, 16'd0);
		// id zero goes into the top free slot but keeps it free
		send_req(OP_SET, 8'd0, 8'h5A, 16'd7);
		t = pool_timer(0);
		send_req(OP_SET, t.id, t.param, 16'd0);
		t = pool_timer(1);
		send_req(OP_SET, t.id, t.param, 16'hFFFF);
		t = pool_timer(0);
		send_req(OP_SET, t.id, t.param, 16'd1);
		send_req(OP_TICK, 8'd0, 8'd0, 16'd0);
		send_req(OP_TICK, 8'hFF, 8'hFF, 16'hFFFF);
		send_req(OP_POST, 8'd0, 8'hAA, 16'd0);
		send_req(OP_POP, 8'd0, 8'd0, 16'd0);
		send_req(OP_POP, 8'd0, 8'd0, 16'd0);
		send_req(OP_POP, 8'd0, 8'd0, 16'd0);
		for (int k = 2; k < TIMERS; k++) begin
			t = pool_timer(k);
			send_req(OP_SET, t.id, t.param, 16'd0);
		end
		// table is full now
		send_req(OP_SET, 8'd9, 8'd9, 16'd5);
		send_req(OP_SET, 8'd0, 8'd0, 16'd0);
		// overflow the ring
		repeat (3) send_req(OP_TICK, 8'd0, 8'd0, 16'd0);
		send_req(OP_POST, 8'hFF, 8'hFF, 16'hFFFF);
		send_req(OP_POP, 8'd0, 8'd0, 16'd0);
		wait_drained();

		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n == RANDOM_REQS / 2)
				wait_drained();
			drain_mix = ((n / 150) % 2) == 1;
			pick      = $urandom_range(0, 99);
			id        = 8'($urandom);
			par       = 8'($urandom);
			per       = 16'($urandom);
			if (pick < (drain_mix ? 5 : 30)) begin
				op = OP_TICK;
			end else if (pick < (drain_mix ? 20 : 50)) begin
				op = OP_SET;
				if ($urandom_range(0, 3) != 0) begin
					t   = pool_timer($urandom_range(0, TIMERS - 1));
					id  = t.id;
					par = t.param;
				end
				// keep most periods short so timers fire often
				if ($urandom_range(0, 3) != 0)
					per = 16'($urandom_range(0, 5));
			end else if (pick < (drain_mix ? 30 : 70)) begin
				op = OP_POST;
				if ($urandom_range(0, 7) == 0)
					id = '0;
			end else begin
				op = OP_POP;
			end
			send_req(op, id, par, per);
		end
		wait_drained();
		repeat (TIMERS + 8) @(posedge clk);

		$display("covered %0d requests over all four operations, table full and ring overflow",
			sent);
		$display("with a %0d-cycle receiver hold-off and a full drain mid-run", LONG_HOLD);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_periodic_timer_event_queue: clean");
		end else begin
			$display("tb_periodic_timer_event_queue: errors");
		end
		$finish;
	end

endmodule
